[design/ffba_pkg.sv]
// Package for the first-fit block allocator: sizes, status codes and command types.
// Used by ffba_ctrl, ffba_datapath and first_fit_block_allocator. No dependencies.
package ffba_pkg;
    localparam int MaxSegments = 64;
    localparam int AddressBits = 16;
    localparam int IdxBits     = $clog2(MaxSegments);
    localparam int CntBits     = $clog2(MaxSegments + 1);
    localparam int SizeBits    = 17;
    localparam logic [SizeBits-1:0] MemLimit = SizeBits'(1) << AddressBits;

    // Register address of memory_size on the configuration port.
    localparam logic [1:0] RegMemorySize = 2'd0;

    localparam logic [2:0] StAllocated = 3'd0;
    localparam logic [2:0] StNoFit     = 3'd1;
    localparam logic [2:0] StFull      = 3'd2;
    localparam logic [2:0] StFreed     = 3'd3;
    localparam logic [2:0] StNotFound  = 3'd4;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        t_CMD_NONE,
        t_CMD_INIT,
        t_CMD_LOAD,
        t_CMD_RD,
        t_CMD_RD_PREV,
        t_CMD_RD_NEXT,
        t_CMD_SHIFT_UP,
        t_CMD_SHIFT_DOWN,
        t_CMD_SPLIT,
        t_CMD_EXACT,
        t_CMD_MARK_FREE,
        t_CMD_MERGE_PREV,
        t_CMD_MERGE_NEXT
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [IdxBits-1:0] idx;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic                  free;
        logic [SizeBits-1:0]   len;
        logic [AddressBits-1:0] start;
        logic [CntBits-1:0]    count;
    } t_sts;
endpackage

[design/ffba_datapath.sv]
// Segment table datapath of the first-fit block allocator: memories and count.
// Depends on ffba_pkg. Driven by commands from ffba_ctrl.
module ffba_datapath import ffba_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic [SizeBits-1:0]     i_mem_size,
    input  logic [SizeBits-1:0]     i_req,
    output t_sts                    o_sts
);
    logic [AddressBits-1:0] r_start_mem [MaxSegments];
    logic [SizeBits-1:0]    r_len_mem   [MaxSegments];
    logic                   r_free_mem  [MaxSegments];
    logic [CntBits-1:0]     r_count;
    logic [AddressBits-1:0] r_start;
    logic [SizeBits-1:0]    r_len;
    logic                   r_free;
    logic [SizeBits-1:0]    r_prev_len;
    logic [IdxBits-1:0]     idx;
    logic [IdxBits-1:0]     idx_p1;

    assign idx    = i_ctl.idx;
    assign idx_p1 = idx + IdxBits'(1);

    // Segment count, set to one on reset and on table init.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CntBits'(1);
        end else begin
            case (i_ctl.cmd)
                t_CMD_INIT:       r_count <= CntBits'(1);
                t_CMD_SPLIT:      r_count <= r_count + CntBits'(1);
                t_CMD_MERGE_PREV,
                t_CMD_MERGE_NEXT: r_count <= r_count - CntBits'(1);
                default:          r_count <= r_count;
            endcase
        end
    end

    // Table memories: a read or a write per command, read data registered.
    // The read register holds the entry just read; r_prev_len keeps the length
    // of the entry read before it.
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            t_CMD_INIT: begin
                r_start_mem[0] <= '0;
                r_len_mem[0]   <= i_mem_size;
                r_free_mem[0]  <= 1'b1;
            end
            t_CMD_RD: begin
                r_start    <= r_start_mem[idx];
                r_len      <= r_len_mem[idx];
                r_free     <= r_free_mem[idx];
                r_prev_len <= r_len;
            end
            t_CMD_RD_PREV: begin
                r_start    <= r_start_mem[idx - IdxBits'(1)];
                r_len      <= r_len_mem[idx - IdxBits'(1)];
                r_free     <= r_free_mem[idx - IdxBits'(1)];
                r_prev_len <= r_len;
            end
            t_CMD_RD_NEXT: begin
                r_start    <= r_start_mem[idx_p1];
                r_len      <= r_len_mem[idx_p1];
                r_free     <= r_free_mem[idx_p1];
                r_prev_len <= r_len;
            end
            // Read the entry at idx into the register for a later shift write.
            t_CMD_LOAD: begin
                r_start <= r_start_mem[idx];
                r_len   <= r_len_mem[idx];
                r_free  <= r_free_mem[idx];
            end
            t_CMD_SHIFT_UP: begin
                r_start_mem[idx] <= r_start;
                r_len_mem[idx]   <= r_len;
                r_free_mem[idx]  <= r_free;
            end
            t_CMD_SHIFT_DOWN: begin
                r_start_mem[idx] <= r_start;
                r_len_mem[idx]   <= r_len;
                r_free_mem[idx]  <= r_free;
            end
            // Writes the free remainder at idx; r_start/r_len hold the fitting segment.
            t_CMD_SPLIT: begin
                r_start_mem[idx] <= r_start + i_req[AddressBits-1:0];
                r_len_mem[idx]   <= r_len - i_req;
                r_free_mem[idx]  <= 1'b1;
            end
            // Marks the segment at idx allocated with the requested length.
            t_CMD_EXACT: begin
                r_len_mem[idx]  <= i_req;
                r_free_mem[idx] <= 1'b0;
            end
            t_CMD_MARK_FREE: begin
                r_free_mem[idx] <= 1'b1;
            end
            // Writes the sum of the two lengths read last to the entry at idx.
            t_CMD_MERGE_PREV,
            t_CMD_MERGE_NEXT: begin
                r_len_mem[idx] <= r_prev_len + r_len;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.free  = r_free;
    assign o_sts.len   = r_len;
    assign o_sts.start = r_start;
    assign o_sts.count = r_count;
endmodule

[design/ffba_ctrl.sv]
// Controller of the first-fit block allocator: scans the table and sequences
// splits, merges and entry shifts. Depends on ffba_pkg; drives ffba_datapath.
module ffba_ctrl import ffba_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_init,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_mode,
    input  logic [SizeBits-1:0]     i_request_size,
    input  logic [AddressBits-1:0]  i_block_address,
    output logic [SizeBits-1:0]     o_req,
    output t_ctl                    o_ctl,
    input  t_sts                    i_sts,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [AddressBits-1:0]  o_granted_address,
    output logic [2:0]              o_status
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CHECK, S_INS_LD, S_INS_WR, S_REFETCH, S_SPLIT, S_MARK,
        S_PREV_RD, S_PREV_CHK, S_RM_LD, S_RM_WR, S_NEXT_RD, S_NEXT_LD, S_NEXT_CHK,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [IdxBits-1:0]     r_idx;
    logic [IdxBits-1:0]     r_k;
    logic                   r_mode;
    logic [SizeBits-1:0]    r_req;
    logic [AddressBits-1:0] r_baddr;
    logic                   r_prev_done;
    logic                   r_out_valid;
    logic [AddressBits-1:0] r_out_addr;
    logic [2:0]             r_out_status;
    logic [AddressBits-1:0] r_res_addr;
    logic [2:0]             r_res_status;
    logic                   out_free;
    logic [CntBits-1:0]     idx_ext;
    logic [CntBits-1:0]     k_ext;

    assign out_free = !r_out_valid || !i_stall;
    assign idx_ext  = CntBits'(r_idx);
    assign k_ext    = CntBits'(r_k);
    assign o_stall  = (r_state != S_IDLE) || i_init;
    assign o_req    = r_req;
    assign o_valid  = r_out_valid;
    assign o_granted_address = r_out_addr;
    assign o_status = r_out_status;

    // Command to the datapath for the current state.
    always_comb begin
        o_ctl.cmd = t_CMD_NONE;
        o_ctl.idx = r_idx;
        if (i_init) begin
            o_ctl.cmd = t_CMD_INIT;
        end else begin
            case (r_state)
                S_RD:      o_ctl.cmd = t_CMD_RD;
                S_INS_LD: begin
                    o_ctl.cmd = t_CMD_LOAD;
                    o_ctl.idx = r_k - IdxBits'(1);
                end
                S_INS_WR: begin
                    o_ctl.cmd = t_CMD_SHIFT_UP;
                    o_ctl.idx = r_k;
                end
                S_REFETCH: o_ctl.cmd = t_CMD_RD;
                S_SPLIT: begin
                    o_ctl.cmd = t_CMD_SPLIT;
                    o_ctl.idx = r_idx + IdxBits'(1);
                end
                S_MARK:     o_ctl.cmd = r_mode ? t_CMD_MARK_FREE : t_CMD_EXACT;
                S_PREV_RD:  o_ctl.cmd = t_CMD_RD_PREV;
                S_PREV_CHK: o_ctl.cmd = t_CMD_RD;
                S_NEXT_RD:  o_ctl.cmd = t_CMD_RD;
                S_NEXT_LD:  o_ctl.cmd = t_CMD_RD_NEXT;
                S_RM_LD: begin
                    o_ctl.cmd = t_CMD_LOAD;
                    o_ctl.idx = r_k + IdxBits'(1);
                end
                S_RM_WR: begin
                    o_ctl.cmd = t_CMD_SHIFT_DOWN;
                    o_ctl.idx = r_k;
                end
                S_NEXT_CHK: begin
                    if (i_sts.free && ({1'b0, idx_ext} + 1'b1 < {1'b0, i_sts.count})) begin
                        o_ctl.cmd = t_CMD_MERGE_NEXT;
                    end
                end
                default: o_ctl.cmd = t_CMD_NONE;
            endcase
            // Merge into the predecessor: lengths of idx-1 and idx were read last.
            if (r_state == S_PREV_CHK && r_prev_done) begin
                o_ctl.cmd = t_CMD_MERGE_PREV;
                o_ctl.idx = r_idx - IdxBits'(1);
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_prev_done <= 1'b0;
        end else begin
            // The result register fills in S_DONE and empties when taken.
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode  <= i_mode;
                        r_req   <= i_request_size;
                        r_baddr <= i_block_address;
                        r_idx   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_CHECK;
                // Examine entry r_idx.
                S_CHECK: begin
                    if (!r_mode) begin
                        if (r_req == '0) begin
                            r_res_status <= StNoFit;
                            r_res_addr   <= '0;
                            r_state      <= S_DONE;
                        end else if (i_sts.free && i_sts.len >= r_req) begin
                            if (i_sts.len > r_req &&
                                i_sts.count >= CntBits'(MaxSegments)) begin
                                r_res_status <= StFull;
                                r_res_addr   <= '0;
                                r_state      <= S_DONE;
                            end else if (i_sts.len > r_req) begin
                                r_res_addr   <= i_sts.start;
                                r_res_status <= StAllocated;
                                r_k          <= IdxBits'(i_sts.count);
                                r_state      <= (IdxBits'(i_sts.count) == r_idx + IdxBits'(1))
                                                ? S_SPLIT : S_INS_LD;
                            end else begin
                                r_res_addr   <= i_sts.start;
                                r_res_status <= StAllocated;
                                r_state      <= S_MARK;
                            end
                        end else if (idx_ext + CntBits'(1) >= i_sts.count) begin
                            r_res_status <= StNoFit;
                            r_res_addr   <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_idx   <= r_idx + IdxBits'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_res_addr <= '0;
                        if (i_sts.start == r_baddr) begin
                            r_res_status <= StFreed;
                            r_state      <= S_MARK;
                        end else if (idx_ext + CntBits'(1) >= i_sts.count) begin
                            r_res_status <= StNotFound;
                            r_state      <= S_DONE;
                        end else begin
                            r_idx   <= r_idx + IdxBits'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                // Shift entries up by one, from the top down to r_idx+2.
                S_INS_LD: r_state <= S_INS_WR;
                S_INS_WR: begin
                    r_k     <= r_k - IdxBits'(1);
                    r_state <= (r_k - IdxBits'(1) == r_idx + IdxBits'(1)) ? S_REFETCH
                               : S_INS_LD;
                end
                // The shifts overwrote the read register; read the fitting entry again.
                S_REFETCH: r_state <= S_SPLIT;
                S_SPLIT: r_state <= S_MARK;
                S_MARK: begin
                    if (r_mode) begin
                        r_state <= (r_idx != '0) ? S_PREV_RD : S_NEXT_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_PREV_RD: r_state <= S_PREV_CHK;
                // First pass checks the predecessor; second pass merges.
                S_PREV_CHK: begin
                    if (r_prev_done) begin
                        r_prev_done <= 1'b0;
                        r_k         <= r_idx;
                        r_idx       <= r_idx - IdxBits'(1);
                        r_state     <= (idx_ext + CntBits'(1) < i_sts.count) ? S_RM_LD
                                       : S_NEXT_RD;
                    end else if (i_sts.free) begin
                        r_prev_done <= 1'b1;
                    end else begin
                        r_state <= S_NEXT_RD;
                    end
                end
                // Remove entry r_k by shifting the tail down.
                S_RM_LD: r_state <= S_RM_WR;
                S_RM_WR: begin
                    r_k     <= r_k + IdxBits'(1);
                    r_state <= (k_ext + CntBits'(2) < i_sts.count + CntBits'(1)) ? S_RM_LD
                               : S_NEXT_RD;
                end
                // Read entry r_idx, then its successor.
                S_NEXT_RD: r_state <= S_NEXT_LD;
                S_NEXT_LD: r_state <= S_NEXT_CHK;
                S_NEXT_CHK: begin
                    if (i_sts.free && (idx_ext + CntBits'(1) < i_sts.count)) begin
                        r_k     <= r_idx + IdxBits'(1);
                        r_state <= (idx_ext + CntBits'(2) < i_sts.count) ? S_RM_LD : S_DONE;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_addr   <= r_res_addr;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[design/first_fit_block_allocator.sv]
// First-fit block allocator with coalescing.
// Request channel: i_valid/o_stall carrying i_mode, i_request_size and
// i_block_address. Result channel: o_valid/i_stall carrying o_granted_address
// and o_status. A request is taken when valid is high and stall is low.
// Mode 0 allocates from the first free segment that fits, splitting off the
// remainder; mode 1 frees the segment at the given offset and merges it with
// free neighbors.
// One request is handled at a time. A request scans the table one entry at a
// time from index 0, and a split or merge then shifts the table entries that
// lie above it; the table holds up to 64 entries.
// The result is held in an output register until taken; while the receiver
// stalls, the block finishes at most one more request and then waits.
// Reset (synchronous, active low) and a write of memory_size over the APB
// port both reset the table to one free segment covering the memory; the size
// is taken from pwdata[16:0], and a value above 65536 saturates to 65536.
// Depends on ffba_pkg, ffba_ctrl and ffba_datapath.
module first_fit_block_allocator import ffba_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [1:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_mode,
    input  logic [SizeBits-1:0]     i_request_size,
    input  logic [AddressBits-1:0]  i_block_address,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [AddressBits-1:0]  o_granted_address,
    output logic [2:0]              o_status
);
    logic [SizeBits-1:0] r_mem_size;
    logic [SizeBits-1:0] n_mem_size;
    logic                r_init;
    logic                cfg_wr;
    logic [SizeBits-1:0] req;
    t_ctl                ctl;
    t_sts                sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == RegMemorySize);
    assign prdata = (paddr == RegMemorySize) ? 32'(r_mem_size) : 32'd0;

    // Saturate the written size to the address space.
    always_comb begin
        n_mem_size = pwdata[SizeBits-1:0];
        if (n_mem_size > MemLimit) begin
            n_mem_size = MemLimit;
        end
    end

    // Size register; a write or reset requests a table init next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size <= MemLimit;
            r_init     <= 1'b1;
        end else begin
            r_init <= cfg_wr;
            if (cfg_wr) begin
                r_mem_size <= n_mem_size;
            end
        end
    end

    ffba_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_init            (r_init),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_request_size    (i_request_size),
        .i_block_address   (i_block_address),
        .o_req             (req),
        .o_ctl             (ctl),
        .i_sts             (sts),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_granted_address (o_granted_address),
        .o_status          (o_status)
    );

    ffba_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_mem_size (r_mem_size),
        .i_req      (req),
        .o_sts      (sts)
    );
endmodule
